/* rtl/core/ilacc_pkg.sv */
// ----------------------------------------------------------------------------
// ilacc_pkg
// shared types and codes of the instruction-list accumulator unit
// ----------------------------------------------------------------------------
package ilacc_pkg;

    localparam int ADDR_BITS_DEF = 16;
    localparam int QUEUE_DEPTH   = 2;

    typedef enum logic [4:0] {
        OP_LD = 5'd0, OP_LDN = 5'd1, OP_NOT = 5'd2, OP_ADD = 5'd3, OP_SUB = 5'd4,
        OP_MUL = 5'd5, OP_DIV = 5'd6, OP_GT = 5'd7, OP_GE = 5'd8, OP_EQ = 5'd9,
        OP_NE = 5'd10, OP_LE = 5'd11, OP_LT = 5'd12, OP_S = 5'd13, OP_R = 5'd14,
        OP_AND = 5'd15, OP_ANDN = 5'd16, OP_OR = 5'd17, OP_ORN = 5'd18,
        OP_XOR = 5'd19, OP_XORN = 5'd20, OP_ST = 5'd21, OP_STN = 5'd22,
        OP_JMP = 5'd23, OP_JMPC = 5'd24, OP_JMPCN = 5'd25, OP_RET = 5'd26
    } op_t;

    localparam logic [1:0] KIND_NONE = 2'd0;
    localparam logic [1:0] KIND_INT  = 2'd1;
    localparam logic [1:0] KIND_BOOL = 2'd2;

    localparam logic [1:0] EMIT_NONE  = 2'd0;
    localparam logic [1:0] EMIT_VALUE = 2'd1;
    localparam logic [1:0] EMIT_TRUE  = 2'd2;
    localparam logic [1:0] EMIT_FALSE = 2'd3;

    // classified instruction handed from front to back
    typedef struct packed {
        logic [4:0]  action;
        logic [63:0] operand;
        logic        is_div;
        logic        is_mul;
    } instr_t;

endpackage

/* rtl/core/ilacc_front.sv */
// ----------------------------------------------------------------------------
// ilacc_front
// accepts instructions, classifies them and queues them for the back end
// ----------------------------------------------------------------------------
module ilacc_front
    import ilacc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [4:0]  in_action,
    input  logic [63:0] in_operand,
    output logic        q_valid,
    input  logic        q_ready,
    output instr_t      q_data
);
    instr_t     slot_reg [QUEUE_DEPTH];
    logic       wp_reg, wp_next, rp_reg, rp_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       push, pop;
    instr_t     cls;

    always_comb begin
        cls.action  = in_action;
        cls.operand = in_operand;
        cls.is_div  = (in_action == OP_DIV);
        cls.is_mul  = (in_action == OP_MUL);
    end

    assign in_ready = (cnt_reg != 2'(QUEUE_DEPTH));
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_data   = slot_reg[rp_reg];
    assign push     = in_valid && in_ready;
    assign pop      = q_valid && q_ready;

    always_comb begin
        wp_next  = push ? ~wp_reg : wp_reg;
        rp_next  = pop ? ~rp_reg : rp_reg;
        cnt_next = cnt_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end else begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wp_reg] <= cls;
        end
    end

`ifndef ASSERT_OFF
    a_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= 2'(QUEUE_DEPTH)) else $error("queue count out of range");
    a_full_noready: assert property (@(posedge aclk) disable iff (!aresetn)
        (cnt_reg == 2'(QUEUE_DEPTH)) |-> !in_ready) else $error("ready when full");
    a_empty_ptrs: assert property (@(posedge aclk) disable iff (!aresetn)
        (cnt_reg == 2'd0) |-> (wp_reg == rp_reg)) else $error("pointer mismatch");
`endif
endmodule

/* rtl/core/ilacc_back.sv */
// ----------------------------------------------------------------------------
// ilacc_back
// executes queued instructions on the accumulator, iterative divider
// ----------------------------------------------------------------------------
module ilacc_back
    import ilacc_pkg::*;
#(
    parameter int ADDR_BITS = ADDR_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        q_valid,
    output logic        q_ready,
    input  instr_t      q_data,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [63:0] m_acc_value,
    output logic [1:0]  m_acc_kind,
    output logic [1:0]  m_emit_kind,
    output logic [63:0] m_emit_value,
    output logic        m_branch_taken,
    output logic [15:0] m_branch_target,
    output logic        m_halt,
    output logic        m_arith_error
);
    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001, ST_MUL = 4'b0010, ST_DIV = 4'b0100, ST_OUT = 4'b1000
    } state_t;

    state_t      state_reg, state_next;
    logic [63:0] acc_reg, acc_next;
    logic [1:0]  kind_reg, kind_next;
    logic [63:0] opnd_reg;
    logic [4:0]  op_reg;
    // divider
    logic [63:0] quo_reg, rem_reg, dvs_reg;
    logic [6:0]  step_reg;
    logic        neg_reg;
    // multiplier partial products (32x32 each)
    logic [1:0]  mstep_reg;
    logic [63:0] mprod_reg;
    logic [63:0] pp;
    logic [31:0] ma, mb;

    logic [63:0] r_emit_val;
    logic [1:0]  r_emit_kind;
    logic        r_taken, r_halt, r_err;
    logic [63:0] trial;
    logic [64:0] rem_sh;
    logic        issue, out_free;

    assign out_free = !m_valid || m_ready;
    // side fields of a waiting result are written at issue, so hold issue until it leaves
    assign q_ready  = (state_reg == ST_IDLE) && out_free;
    assign issue    = q_valid && q_ready;

    // combinational terms for the ops
    logic        acc_t, arg_t, isb, sgt_ao, sgt_oa, div_bad;
    logic [63:0] arg;
    always_comb begin
        arg    = q_data.operand;
        acc_t  = (acc_reg != 64'd0);
        arg_t  = (arg != 64'd0);
        isb    = (kind_reg == KIND_BOOL);
        sgt_ao = ($signed(acc_reg) > $signed(arg));
        sgt_oa = ($signed(arg) > $signed(acc_reg));
        div_bad = !arg_t || (acc_reg == 64'h8000_0000_0000_0000 && arg == '1);
    end

    // mul: low 64 bits = al*bl + ((ah*bl + al*bh) << 32)
    always_comb begin
        case (mstep_reg)
            2'd0:    begin ma = acc_reg[31:0];  mb = opnd_reg[31:0];  end
            2'd1:    begin ma = acc_reg[63:32]; mb = opnd_reg[31:0];  end
            default: begin ma = acc_reg[31:0];  mb = opnd_reg[63:32]; end
        endcase
        pp = ma * mb;
    end

    assign rem_sh = {rem_reg, quo_reg[63]};
    assign trial  = rem_sh[63:0] - dvs_reg;

    always_comb begin
        state_next = state_reg;
        acc_next   = acc_reg;
        kind_next  = kind_reg;
        case (state_reg)
            ST_IDLE: begin
                if (issue) begin
                    case (q_data.action)
                        OP_LD:  begin acc_next = arg; kind_next = KIND_INT; end
                        OP_LDN: begin acc_next = 64'd0 - arg; kind_next = KIND_INT; end
                        OP_NOT: begin
                            if (kind_reg == KIND_INT) acc_next = 64'd0 - acc_reg;
                            else if (isb) acc_next = {63'd0, !acc_t};
                            else acc_next = 64'd0;
                        end
                        OP_ADD: acc_next = acc_reg + arg;
                        OP_SUB: acc_next = acc_reg - arg;
                        OP_GT:  begin acc_next = {63'd0, sgt_ao}; kind_next = KIND_BOOL; end
                        OP_GE:  begin acc_next = {63'd0, !sgt_oa}; kind_next = KIND_BOOL; end
                        OP_EQ:  begin acc_next = {63'd0, acc_reg == arg}; kind_next = KIND_BOOL; end
                        OP_NE:  begin acc_next = {63'd0, acc_reg != arg}; kind_next = KIND_BOOL; end
                        OP_LE:  begin acc_next = {63'd0, !sgt_ao}; kind_next = KIND_BOOL; end
                        OP_LT:  begin acc_next = {63'd0, sgt_oa}; kind_next = KIND_BOOL; end
                        OP_AND: begin acc_next = {63'd0, acc_t && arg_t}; kind_next = KIND_BOOL; end
                        OP_ANDN: begin acc_next = {63'd0, acc_t && !arg_t}; kind_next = KIND_BOOL; end
                        OP_OR:  begin acc_next = {63'd0, acc_t || arg_t}; kind_next = KIND_BOOL; end
                        OP_ORN: begin acc_next = {63'd0, acc_t || !arg_t}; kind_next = KIND_BOOL; end
                        OP_XOR: begin acc_next = acc_reg ^ arg; kind_next = KIND_BOOL; end
                        OP_XORN: begin acc_next = acc_reg ^ {63'd0, !arg_t}; kind_next = KIND_BOOL; end
                        default: ;
                    endcase
                    if (q_data.is_mul) state_next = ST_MUL;
                    else if (q_data.is_div && !div_bad) state_next = ST_DIV;
                    else state_next = ST_OUT;
                end
            end
            ST_MUL: begin
                if (mstep_reg == 2'd2) begin
                    acc_next   = mprod_reg + {pp[31:0], 32'd0};
                    state_next = ST_OUT;
                end
            end
            ST_DIV: begin
                if (step_reg == 7'd64) begin
                    acc_next   = neg_reg ? 64'd0 - quo_reg : quo_reg;
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (out_free) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // result fields computed from pre-instruction state at issue
    always_comb begin
        r_emit_kind = EMIT_NONE;
        r_emit_val  = 64'd0;
        r_taken     = 1'b0;
        r_halt      = 1'b0;
        r_err       = 1'b0;
        case (q_data.action)
            OP_DIV: r_err = div_bad;
            OP_S:   if (isb && acc_reg == 64'd1) r_emit_kind = EMIT_TRUE;
            OP_R:   if (isb && !acc_t) r_emit_kind = EMIT_FALSE;
            OP_ST:  begin r_emit_kind = EMIT_VALUE; r_emit_val = acc_reg; end
            OP_STN: if (kind_reg == KIND_INT) begin
                r_emit_kind = EMIT_VALUE; r_emit_val = 64'd0 - acc_reg;
            end
            OP_JMP:   r_taken = 1'b1;
            OP_JMPC:  r_taken = isb && acc_reg == 64'd1;
            OP_JMPCN: r_taken = isb && !acc_t;
            OP_RET:   r_halt = 1'b1;
            default: ;
        endcase
    end

    localparam int TB = (ADDR_BITS < 16) ? ADDR_BITS : 16;
    logic [15:0] tgt;
    assign tgt = r_taken ? 16'(arg[TB-1:0]) : 16'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            acc_reg   <= 64'd0;
            kind_reg  <= KIND_NONE;
            m_valid   <= 1'b0;
        end else begin
            state_reg <= state_next;
            acc_reg   <= acc_next;
            kind_reg  <= kind_next;
            if (state_reg == ST_OUT && out_free) m_valid <= 1'b1;
            else if (m_ready) m_valid <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (issue) begin
            op_reg          <= q_data.action;
            opnd_reg        <= arg;
            m_emit_kind     <= r_emit_kind;
            m_emit_value    <= r_emit_val;
            m_branch_taken  <= r_taken;
            m_branch_target <= tgt;
            m_halt          <= r_halt;
            m_arith_error   <= r_err;
            mstep_reg       <= 2'd0;
            step_reg        <= 7'd0;
            quo_reg         <= acc_reg[63] ? 64'd0 - acc_reg : acc_reg;
            dvs_reg         <= arg[63] ? 64'd0 - arg : arg;
            rem_reg         <= 64'd0;
            neg_reg         <= acc_reg[63] ^ arg[63];
        end else begin
            if (state_reg == ST_MUL) begin
                mstep_reg <= mstep_reg + 2'd1;
                if (mstep_reg == 2'd0) mprod_reg <= pp;
                else mprod_reg <= mprod_reg + {pp[31:0], 32'd0};
            end
            if (state_reg == ST_DIV && step_reg != 7'd64) begin
                step_reg <= step_reg + 7'd1;
                if (!rem_sh[64] && rem_sh[63:0] < dvs_reg) begin
                    rem_reg <= rem_sh[63:0];
                    quo_reg <= {quo_reg[62:0], 1'b0};
                end else begin
                    rem_reg <= trial;
                    quo_reg <= {quo_reg[62:0], 1'b1};
                end
            end
        end
        if (state_reg == ST_OUT && out_free) begin
            m_acc_value <= acc_reg;
            m_acc_kind  <= kind_reg;
        end
    end

`ifndef ASSERT_OFF
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> $stable(m_acc_value)) else $error("result changed");
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_IDLE) |-> !q_ready) else $error("issue while busy");
    a_divlen: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIV) |-> (step_reg <= 7'd64)) else $error("divide overrun");
    a_op: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_MUL) |-> (op_reg == OP_MUL)) else $error("mul state bad op");
`endif
endmodule

/* rtl/core/instruction_list_accumulator_unit_core.sv */
// ----------------------------------------------------------------------------
// instruction_list_accumulator_unit_core
// execute unit of an instruction-list accumulator machine
// ----------------------------------------------------------------------------
// One result per instruction. A front queue of two entries takes requests
// while the back end works. Most instructions pass from the queue read and
// execute step to the output register, and the back end takes no new request
// until the last one has left execute; MUL steps through a shared 32x32
// multiplier, and a valid DIV runs in the bit-serial restoring divider,
// which is the slowest path. Faulting divides finish in the short path. A
// result left waiting on m_ready holds the back end until it is taken.
module instruction_list_accumulator_unit_core
    import ilacc_pkg::*;
#(
    parameter int ADDR_BITS = ADDR_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [4:0]  s_action,
    input  logic [63:0] s_operand,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [63:0] m_acc_value,
    output logic [1:0]  m_acc_kind,
    output logic [1:0]  m_emit_kind,
    output logic [63:0] m_emit_value,
    output logic        m_branch_taken,
    output logic [15:0] m_branch_target,
    output logic        m_halt,
    output logic        m_arith_error
);
    // queue between front and back
    logic   q_valid, q_ready;
    instr_t q_data;

    ilacc_front u_front (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(s_valid), .in_ready(s_ready),
        .in_action(s_action), .in_operand(s_operand),
        .q_valid(q_valid), .q_ready(q_ready), .q_data(q_data)
    );

    // execute with accumulator state
    ilacc_back #(.ADDR_BITS(ADDR_BITS)) u_back (
        .aclk(aclk), .aresetn(aresetn),
        .q_valid(q_valid), .q_ready(q_ready), .q_data(q_data),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_acc_value(m_acc_value), .m_acc_kind(m_acc_kind),
        .m_emit_kind(m_emit_kind), .m_emit_value(m_emit_value),
        .m_branch_taken(m_branch_taken), .m_branch_target(m_branch_target),
        .m_halt(m_halt), .m_arith_error(m_arith_error)
    );
endmodule
